// File: sv/arsi_pkg.sv
// Shared types and codes for the adaptive range split index.
// Used by the top level; has no dependencies.
`default_nettype none
package arsi_pkg;

  typedef enum logic [2:0] {
    ST_PUSHED   = 3'd0,
    ST_POPPED   = 3'd1,
    ST_POP_NONE = 3'd2,
    ST_FULL     = 3'd3,
    ST_REJECTED = 3'd4
  } status_t;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  localparam logic [31:0] KEY_ALL_ONES = 32'hFFFF_FFFF;
  localparam logic [7:0]  THRESHOLD_RESET = 8'd64;

  typedef struct packed {
    logic        live;
    logic [31:0] key;
    logic [31:0] value;
  } entry_t;

endpackage
`default_nettype wire

// File: sv/arsi_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`default_nettype none
module arsi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: sv/adaptive_range_split_index.sv
// Top level of the adaptive range split index: range table and entry lists in RAM.
// Depends on arsi_pkg and arsi_ram.
//
// A request is taken when start is high and busy is low; its single result appears
// on the out_ ports for one cycle with out_strobe and cannot be stalled. After reset
// the block writes the initial range in S_INIT before busy drops. A request first
// finds its range by reading the range table in order, then pushes into or pops
// from that range's list, reading the list in order for a pop; all steps are limited
// by the single read port of each RAM. A split also shifts the range table and divides the list.
`default_nettype none
module adaptive_range_split_index
  import arsi_pkg::*;
#(
  parameter int MAX_RANGES = 64,
  parameter int LIST_DEPTH = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_command,
  input  wire logic [31:0] in_key,
  input  wire logic [31:0] in_payload,
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_wdata,
  output logic             out_strobe,
  output logic [2:0]       out_status,
  output logic [31:0]      out_popped_value,
  output logic [6:0]       out_ranges_in_use
);

  localparam int RW   = $clog2(MAX_RANGES);
  localparam int CW   = $clog2(MAX_RANGES + 1);
  localparam int LW   = $clog2(LIST_DEPTH + 1);
  localparam int IW   = $clog2(LIST_DEPTH);
  localparam int ED   = MAX_RANGES * LIST_DEPTH;
  localparam int EAW  = $clog2(ED);
  localparam int CMPW = (LW > 8) ? LW : 8;

  typedef struct packed {
    logic [31:0]   lo;
    logic [31:0]   up;
    logic [LW-1:0] len;
    logic [RW-1:0] slot;
  } meta_t;

  localparam int MW = $bits(meta_t);
  localparam int EW = $bits(entry_t);

  typedef enum logic [9:0] {
    S_INIT    = 10'b00_0000_0001,
    S_IDLE    = 10'b00_0000_0010,
    S_FIND    = 10'b00_0000_0100,
    S_DECIDE  = 10'b00_0000_1000,
    S_SHIFT   = 10'b00_0001_0000,
    S_SCAN    = 10'b00_0010_0000,
    S_META_LO = 10'b00_0100_0000,
    S_META_HI = 10'b00_1000_0000,
    S_OP      = 10'b01_0000_0000,
    S_POP     = 10'b10_0000_0000
  } state_t;

  state_t        state_r, state_nxt;
  logic          cmd_r, cmd_nxt;
  logic [31:0]   key_r, key_nxt, pay_r, pay_nxt;
  logic [7:0]    thr_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [RW-1:0] r_r, r_nxt, sh_r, sh_nxt;
  logic [31:0]   lo_r, lo_nxt, up_r, up_nxt, piv_r, piv_nxt;
  logic [LW-1:0] len_r, len_nxt, i_r, i_nxt, nlo_r, nlo_nxt, nhi_r, nhi_nxt;
  logic [RW-1:0] slot_r, slot_nxt;
  logic          pend_r, pend_nxt;
  logic [IW-1:0] pidx_r, pidx_nxt;
  logic          ostb_r, ostb_nxt;
  status_t       ost_r, ost_nxt;
  logic [31:0]   oval_r, oval_nxt;
  logic [6:0]    orng_r, orng_nxt;

  logic           m_we;
  logic [RW-1:0]  m_waddr, m_raddr;
  meta_t          m_wdata, m_rdata;
  logic           e_we;
  logic [EAW-1:0] e_waddr, e_raddr;
  entry_t         e_wdata, e_rdata;

  logic [31:0] half;
  logic        issue;

  function automatic logic [EAW-1:0] eaddr(input logic [RW-1:0] slot,
                                           input logic [IW-1:0] idx);
    eaddr = EAW'(slot) * EAW'(LIST_DEPTH) + EAW'(idx);
  endfunction

  arsi_ram #(.WIDTH(MW), .DEPTH(MAX_RANGES)) u_meta_ram (
    .clk   (clk),
    .we    (m_we),
    .waddr (m_waddr),
    .wdata (m_wdata),
    .raddr (m_raddr),
    .rdata (m_rdata)
  );

  arsi_ram #(.WIDTH(EW), .DEPTH(ED)) u_entry_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (e_wdata),
    .raddr (e_raddr),
    .rdata (e_rdata)
  );

  assign busy              = (state_r != S_IDLE);
  assign out_strobe        = ostb_r;
  assign out_status        = ost_r;
  assign out_popped_value  = oval_r;
  assign out_ranges_in_use = orng_r;
  assign half              = (up_r - lo_r) >> 1;
  assign issue             = (i_r < len_r);

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    key_nxt   = key_r;
    pay_nxt   = pay_r;
    cnt_nxt   = cnt_r;
    r_nxt     = r_r;
    sh_nxt    = sh_r;
    lo_nxt    = lo_r;
    up_nxt    = up_r;
    piv_nxt   = piv_r;
    len_nxt   = len_r;
    slot_nxt  = slot_r;
    i_nxt     = i_r;
    nlo_nxt   = nlo_r;
    nhi_nxt   = nhi_r;
    pend_nxt  = pend_r;
    pidx_nxt  = pidx_r;
    ostb_nxt  = 1'b0;
    ost_nxt   = ost_r;
    oval_nxt  = 32'd0;
    orng_nxt  = 7'(cnt_r);
    m_we      = 1'b0;
    m_waddr   = r_r;
    m_wdata   = '{lo: lo_r, up: up_r, len: len_r, slot: slot_r};
    m_raddr   = r_r;
    e_we      = 1'b0;
    e_waddr   = eaddr(slot_r, len_r[IW-1:0]);
    e_wdata   = '{live: 1'b1, key: key_r, value: pay_r};
    e_raddr   = eaddr(slot_r, i_r[IW-1:0]);

    case (state_r)
      S_INIT: begin
        m_we      = 1'b1;
        m_waddr   = '0;
        m_wdata   = '{lo: 32'd0, up: KEY_ALL_ONES, len: '0, slot: '0};
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd_nxt = in_command;
          key_nxt = in_key;
          pay_nxt = in_payload;
          if (in_key == KEY_ALL_ONES) begin
            ostb_nxt = 1'b1;
            ost_nxt  = ST_REJECTED;
          end else begin
            r_nxt     = '0;
            m_raddr   = '0;
            state_nxt = S_FIND;
          end
        end
      end
      S_FIND: begin
        if ((CW'(r_r) + CW'(1) < cnt_r) && (key_r >= m_rdata.up)) begin
          r_nxt   = r_r + RW'(1);
          m_raddr = r_r + RW'(1);
        end else begin
          lo_nxt    = m_rdata.lo;
          up_nxt    = m_rdata.up;
          len_nxt   = m_rdata.len;
          slot_nxt  = m_rdata.slot;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        i_nxt    = '0;
        pend_nxt = 1'b0;
        nlo_nxt  = '0;
        nhi_nxt  = '0;
        piv_nxt  = lo_r + half;
        if ((half != 32'd0) && (CMPW'(len_r) > CMPW'(thr_r)) &&
            (cnt_r < CW'(MAX_RANGES))) begin
          if (CW'(r_r) == cnt_r - CW'(1)) begin
            state_nxt = S_SCAN;
          end else begin
            sh_nxt    = RW'(cnt_r - CW'(1));
            m_raddr   = RW'(cnt_r - CW'(1));
            state_nxt = S_SHIFT;
          end
        end else begin
          state_nxt = S_OP;
        end
      end
      S_SHIFT: begin
        m_we    = 1'b1;
        m_waddr = sh_r + RW'(1);
        m_wdata = m_rdata;
        if (sh_r == r_r + RW'(1)) begin
          state_nxt = S_SCAN;
        end else begin
          sh_nxt  = sh_r - RW'(1);
          m_raddr = sh_r - RW'(1);
        end
      end
      S_SCAN: begin
        pend_nxt = issue;
        if (issue) begin
          i_nxt = i_r + LW'(1);
        end
        e_wdata = e_rdata;
        if (pend_r && e_rdata.live) begin
          e_we = 1'b1;
          if (e_rdata.key < piv_r) begin
            e_waddr = eaddr(slot_r, nlo_r[IW-1:0]);
            nlo_nxt = nlo_r + LW'(1);
          end else begin
            e_waddr = eaddr(RW'(cnt_r), nhi_r[IW-1:0]);
            nhi_nxt = nhi_r + LW'(1);
          end
        end
        if (!issue && !pend_r) begin
          state_nxt = S_META_LO;
        end
      end
      S_META_LO: begin
        m_we      = 1'b1;
        m_waddr   = r_r;
        m_wdata   = '{lo: lo_r, up: piv_r, len: nlo_r, slot: slot_r};
        state_nxt = S_META_HI;
      end
      S_META_HI: begin
        m_we     = 1'b1;
        m_waddr  = r_r + RW'(1);
        m_wdata  = '{lo: piv_r, up: up_r, len: nhi_r, slot: RW'(cnt_r)};
        cnt_nxt  = cnt_r + CW'(1);
        i_nxt    = '0;
        pend_nxt = 1'b0;
        if (key_r >= piv_r) begin
          r_nxt    = r_r + RW'(1);
          lo_nxt   = piv_r;
          len_nxt  = nhi_r;
          slot_nxt = RW'(cnt_r);
        end else begin
          up_nxt  = piv_r;
          len_nxt = nlo_r;
        end
        state_nxt = S_OP;
      end
      S_OP: begin
        if (cmd_r == CMD_PUSH) begin
          ostb_nxt  = 1'b1;
          state_nxt = S_IDLE;
          if (len_r == LW'(LIST_DEPTH)) begin
            ost_nxt = ST_FULL;
          end else begin
            e_we    = 1'b1;
            m_we    = 1'b1;
            m_wdata = '{lo: lo_r, up: up_r, len: len_r + LW'(1), slot: slot_r};
            ost_nxt = ST_PUSHED;
          end
        end else begin
          state_nxt = S_POP;
        end
      end
      S_POP: begin
        pend_nxt = issue;
        pidx_nxt = i_r[IW-1:0];
        if (issue) begin
          i_nxt = i_r + LW'(1);
        end
        if (pend_r && e_rdata.live && (key_r < e_rdata.key)) begin
          e_we      = 1'b1;
          e_waddr   = eaddr(slot_r, pidx_r);
          e_wdata   = '{live: 1'b0, key: e_rdata.key, value: e_rdata.value};
          ostb_nxt  = 1'b1;
          ost_nxt   = ST_POPPED;
          oval_nxt  = e_rdata.value;
          state_nxt = S_IDLE;
        end else if (!issue && !pend_r) begin
          ostb_nxt  = 1'b1;
          ost_nxt   = ST_POP_NONE;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      thr_r   <= THRESHOLD_RESET;
      cnt_r   <= CW'(1);
      ostb_r  <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end
      cnt_r  <= cnt_nxt;
      ostb_r <= ostb_nxt;
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    key_r  <= key_nxt;
    pay_r  <= pay_nxt;
    r_r    <= r_nxt;
    sh_r   <= sh_nxt;
    lo_r   <= lo_nxt;
    up_r   <= up_nxt;
    piv_r  <= piv_nxt;
    len_r  <= len_nxt;
    slot_r <= slot_nxt;
    i_r    <= i_nxt;
    nlo_r  <= nlo_nxt;
    nhi_r  <= nhi_nxt;
    pidx_r <= pidx_nxt;
    ost_r  <= ost_nxt;
    oval_r <= oval_nxt;
    orng_r <= orng_nxt;
  end

`ifndef NO_ASSERTIONS
  a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_key != KEY_ALL_ONES)) |=> busy)
    else $error("busy did not rise after an accepted request");

  a_value_only_on_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_status != ST_POPPED)) |-> (out_popped_value == 32'd0))
    else $error("popped value nonzero without a successful pop");

  a_count_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r >= CW'(1)) && (cnt_r <= CW'(MAX_RANGES)))
    else $error("range count out of bounds");

  a_split_grows_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_META_HI) |=> (cnt_r == $past(cnt_r) + CW'(1)))
    else $error("split did not add a range");

  a_list_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OP) |-> (len_r <= LW'(LIST_DEPTH)))
    else $error("list length above depth");
`endif

endmodule
`default_nettype wire

// File: verif/tb_top.sv
// Self-checking testbench for the adaptive range split index: directed requests, then random
// requests across several split thresholds, with a behavioral predictor of the range table.
// Depends on arsi_pkg and adaptive_range_split_index.
`default_nettype none
module tb_top;
  import arsi_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NRANGE = 64;
  localparam int NDEPTH = 256;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_command;
  logic [31:0] in_key;
  logic [31:0] in_payload;
  logic        cfg_we;
  logic [7:0]  cfg_wdata;
  logic        out_strobe;
  logic [2:0]  out_status;
  logic [31:0] out_popped_value;
  logic [6:0]  out_ranges_in_use;

  adaptive_range_split_index #(.MAX_RANGES(NRANGE), .LIST_DEPTH(NDEPTH)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_key(in_key), .in_payload(in_payload),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_strobe(out_strobe), .out_status(out_status),
    .out_popped_value(out_popped_value), .out_ranges_in_use(out_ranges_in_use)
  );

  typedef struct {
    status_t     status;
    logic [31:0] value;
    logic [6:0]  ranges;
  } outcome_t;

  typedef struct {
    logic        command;
    logic [31:0] key;
    logic [31:0] payload;
    bit          typed;
    outcome_t    want;
  } request_row_t;

  // Predicted range table and entry lists.
  logic [7:0]  threshold;
  logic [31:0] lower_bound [NRANGE];
  logic [31:0] upper_bound [NRANGE];
  int          range_total;
  int          list_len [NRANGE];
  logic [31:0] slot_key [NRANGE][NDEPTH];
  logic [31:0] slot_value [NRANGE][NDEPTH];
  bit          slot_live [NRANGE][NDEPTH];

  outcome_t    pending_outcomes[$];
  int          error_count = 0;
  bit          idle_allowed = 1;
  logic [31:0] key_pool [16];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #60ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic index_reset();
    threshold = THRESHOLD_RESET;
    range_total = 1;
    for (int r = 0; r < NRANGE; r++) begin
      lower_bound[r] = '0;
      upper_bound[r] = '0;
      list_len[r] = 0;
    end
    upper_bound[0] = KEY_ALL_ONES;
  endtask

  function automatic void split_at(input int r, input logic [31:0] pivot);
    logic [31:0] lk [NDEPTH];
    logic [31:0] lv [NDEPTH];
    logic [31:0] hk [NDEPTH];
    logic [31:0] hv [NDEPTH];
    int          nlo;
    int          nhi;
    logic [31:0] top;
    nlo = 0;
    nhi = 0;
    top = upper_bound[r];
    for (int i = 0; i < list_len[r]; i++) begin
      if (slot_live[r][i]) begin
        if (slot_key[r][i] < pivot) begin
          lk[nlo] = slot_key[r][i];
          lv[nlo] = slot_value[r][i];
          nlo++;
        end else begin
          hk[nhi] = slot_key[r][i];
          hv[nhi] = slot_value[r][i];
          nhi++;
        end
      end
    end
    for (int i = range_total; i > r + 1; i--) begin
      lower_bound[i] = lower_bound[i-1];
      upper_bound[i] = upper_bound[i-1];
      list_len[i] = list_len[i-1];
      for (int j = 0; j < NDEPTH; j++) begin
        slot_key[i][j] = slot_key[i-1][j];
        slot_value[i][j] = slot_value[i-1][j];
        slot_live[i][j] = slot_live[i-1][j];
      end
    end
    range_total++;
    upper_bound[r] = pivot;
    lower_bound[r+1] = pivot;
    upper_bound[r+1] = top;
    list_len[r] = nlo;
    list_len[r+1] = nhi;
    for (int i = 0; i < nlo; i++) begin
      slot_key[r][i] = lk[i];
      slot_value[r][i] = lv[i];
      slot_live[r][i] = 1'b1;
    end
    for (int i = 0; i < nhi; i++) begin
      slot_key[r+1][i] = hk[i];
      slot_value[r+1][i] = hv[i];
      slot_live[r+1][i] = 1'b1;
    end
  endfunction

  function automatic outcome_t index_apply(input logic cmd, input logic [31:0] key,
                                           input logic [31:0] payload);
    outcome_t    res;
    int          r;
    logic [31:0] half;
    logic [31:0] pivot;
    res.status = ST_REJECTED;
    res.value = '0;
    r = 0;
    if (key != KEY_ALL_ONES) begin
      while (r + 1 < range_total && key >= upper_bound[r]) r++;
      half = (upper_bound[r] - lower_bound[r]) >> 1;
      if (half >= 1 && list_len[r] > threshold && range_total < NRANGE) begin
        pivot = lower_bound[r] + half;
        split_at(r, pivot);
        if (key >= pivot) r++;
      end
      if (cmd == CMD_PUSH) begin
        if (list_len[r] >= NDEPTH) begin
          res.status = ST_FULL;
        end else begin
          slot_key[r][list_len[r]] = key;
          slot_value[r][list_len[r]] = payload;
          slot_live[r][list_len[r]] = 1'b1;
          list_len[r]++;
          res.status = ST_PUSHED;
        end
      end else begin
        res.status = ST_POP_NONE;
        for (int i = 0; i < list_len[r]; i++) begin
          if (slot_live[r][i] && key < slot_key[r][i]) begin
            slot_live[r][i] = 1'b0;
            res.value = slot_value[r][i];
            res.status = ST_POPPED;
            break;
          end
        end
      end
    end
    res.ranges = 7'(range_total);
    return res;
  endfunction

  task automatic send_request(input logic cmd, input logic [31:0] key, input logic [31:0] payload,
                              input bit typed, input outcome_t want);
    outcome_t got;
    in_command <= cmd;
    in_key <= key;
    in_payload <= payload;
    start <= 1'b1;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    got = index_apply(cmd, key, payload);
    pending_outcomes.push_back(typed ? want : got);
    if (idle_allowed && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  task automatic drain();
    if (start) begin
      start <= 1'b0;
      @(posedge clk);
    end
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [7:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    threshold = value;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_key(input bit for_pop);
    logic [31:0] k;
    case ($urandom_range(0, 9))
      0: k = KEY_ALL_ONES;
      1: k = for_pop ? 32'd0 : 32'hFFFF_FFFE;
      2, 3, 4: k = key_pool[$urandom_range(0, 15)] - (for_pop ? 32'd1 : 32'd0);
      5: k = key_pool[$urandom_range(0, 15)] + 32'($urandom_range(0, 3));
      default: k = $urandom;
    endcase
    return k;
  endfunction

  task automatic random_requests(input int count);
    logic cmd;
    outcome_t none;
    none = '{ST_PUSHED, 32'd0, 7'd0};
    for (int n = 0; n < count; n++) begin
      cmd = ($urandom_range(0, 99) < 55) ? CMD_PUSH : CMD_POP;
      send_request(cmd, pick_key(cmd == CMD_POP), $urandom, 1'b0, none);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (pending_outcomes.size() == 0) begin
        $display("%0t unexpected result: status %0d value %h ranges %0d", $time,
                 out_status, out_popped_value, out_ranges_in_use);
        error_count++;
      end else begin
        if (out_status !== pending_outcomes[0].status) begin
          $display("%0t status: expected %0d actual %0d", $time,
                   pending_outcomes[0].status, out_status);
          error_count++;
        end
        if (out_popped_value !== pending_outcomes[0].value) begin
          $display("%0t popped_value: expected %h actual %h", $time,
                   pending_outcomes[0].value, out_popped_value);
          error_count++;
        end
        if (out_ranges_in_use !== pending_outcomes[0].ranges) begin
          $display("%0t ranges_in_use: expected %0d actual %0d", $time,
                   pending_outcomes[0].ranges, out_ranges_in_use);
          error_count++;
        end
        void'(pending_outcomes.pop_front());
      end
    end
  end

  initial begin
    request_row_t rows[$];
    outcome_t     none;
    logic [31:0]  fixed_key;
    int           guard;
    none = '{ST_PUSHED, 32'd0, 7'd0};
    rst_n <= 1'b0;
    start <= 1'b0;
    in_command <= CMD_PUSH;
    in_key <= '0;
    in_payload <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    index_reset();
    for (int i = 0; i < 16; i++) key_pool[i] = $urandom;
    key_pool[0] = 32'd1;
    key_pool[1] = 32'hFFFF_FFFE;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    rows = '{
      '{CMD_PUSH, KEY_ALL_ONES, 32'h1111_1111, 1, '{ST_REJECTED, 32'd0, 7'd1}},
      '{CMD_POP,  KEY_ALL_ONES, 32'h0, 1, '{ST_REJECTED, 32'd0, 7'd1}},
      '{CMD_POP,  32'd0, 32'h0, 1, '{ST_POP_NONE, 32'd0, 7'd1}},
      '{CMD_PUSH, 32'd0, 32'hFFFF_FFFF, 1, '{ST_PUSHED, 32'd0, 7'd1}},
      '{CMD_PUSH, 32'hFFFF_FFFE, 32'h0, 1, '{ST_PUSHED, 32'd0, 7'd1}},
      '{CMD_PUSH, 32'h8000_0000, 32'h1234_5678, 1, '{ST_PUSHED, 32'd0, 7'd1}},
      '{CMD_POP,  32'hFFFF_FFFE, 32'hDEAD_BEEF, 1, '{ST_POP_NONE, 32'd0, 7'd1}},
      '{CMD_POP,  32'd0, 32'h0, 1, '{ST_POPPED, 32'd0, 7'd1}},
      '{CMD_POP,  32'd0, 32'h0, 1, '{ST_POPPED, 32'h1234_5678, 7'd1}},
      '{CMD_POP,  32'd0, 32'h0, 1, '{ST_POP_NONE, 32'd0, 7'd1}},
      '{CMD_PUSH, 32'd5, 32'hA5A5_A5A5, 0, none},
      '{CMD_PUSH, 32'd3, 32'h5A5A_5A5A, 0, none},
      '{CMD_PUSH, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, none},
      '{CMD_POP,  32'd4, 32'h0, 0, none},
      '{CMD_POP,  32'd2, 32'h0, 0, none},
      '{CMD_POP,  32'h7FFF_FFFE, 32'h0, 0, none},
      '{CMD_POP,  32'd0, 32'h0, 0, none}
    };
    foreach (rows[i]) begin
      send_request(rows[i].command, rows[i].key, rows[i].payload, rows[i].typed, rows[i].want);
    end

    random_requests(50);
    drain();
    write_threshold(8'd2);
    random_requests(70);
    write_threshold(8'd255);
    random_requests(60);
    write_threshold(8'd1);
    random_requests(40);
    write_threshold(8'd16);
    random_requests(40);

    // Split nonempty ranges on each push until the table is full, then overfill one list.
    write_threshold(8'd0);
    idle_allowed = 0;
    guard = 0;
    while (range_total < NRANGE && guard < 400) begin
      send_request(CMD_PUSH, $urandom_range(0, 32'hFFFF_FFFE), $urandom, 1'b0, none);
      guard++;
    end
    fixed_key = key_pool[2];
    for (int n = 0; n < NDEPTH + 6; n++) begin
      send_request(CMD_PUSH, fixed_key, $urandom, 1'b0, none);
    end
    random_requests(20);

    start <= 1'b0;
    guard = 0;
    while (pending_outcomes.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (50) @(posedge clk);
    if (error_count == 0 && pending_outcomes.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire
